// File: design/msort_pkg.sv
// msort_pkg: shared types and constants for the merge sort engine.
// No dependencies; imported by merge_sort_engine.
package msort_pkg;

    localparam int DATA_W = 32;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SEG,
        ST_RD,
        ST_MRG,
        ST_OUT_RD,
        ST_OUT
    } msort_state_t;

endpackage

// File: design/merge_sort_engine.sv
// merge_sort_engine: batch sorter for signed 32-bit items, bottom-up merge sort.
// Depends on msort_pkg (state type, data width).
//
//  Channel   | Dir | tdata (low bit up) | tlast          | tuser
//  ----------+-----+--------------------+----------------+-----------------
//  s_axis    | in  | value[31:0]        | last of batch  | -
//  m_axis    | out | value_res[31:0]    | last sorted    | dropped flag
//
// Loading accepts one item per cycle. Sorting runs one shared compare unit over
// two ping-pong stores in P = max(1, ceil(log2 N)) passes for N items: each run
// pair starts with a segment setup step, and each merged element is read, then
// compared and written. Each result is read from the store before it is offered.
// tready stays low from the last item until the final result is taken.
// Reset clears sequencer, count and flag; only written store entries are used.
module merge_sort_engine #(
    parameter int DEPTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [msort_pkg::DATA_W-1:0]  s_axis_tdata,   // value
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [msort_pkg::DATA_W-1:0]  m_axis_tdata,   // value_res
    output logic                          m_axis_tlast,
    output logic                          m_axis_tuser    // dropped
);
    import msort_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    msort_state_t state_reg, state_next;

    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] width_reg, width_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] mid_reg, mid_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] k_reg, k_next;
    logic          src_reg, src_next;   // 0: store A holds current runs

    // Two ping-pong stores, one write and two registered reads each
    logic [DATA_W-1:0] mem_a [DEPTH];
    logic [DATA_W-1:0] mem_b [DEPTH];
    logic [DATA_W-1:0] a0_reg, a1_reg, b0_reg, b1_reg;

    logic [AW-1:0]     rd_addr0, rd_addr1, wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              wr_a, wr_b;

    logic              in_acc, out_acc;
    logic [DATA_W-1:0] left_val, right_val;
    logic              take_left;
    logic [CW:0]       lo_w, lo_2w, lo_step, width_dbl;
    logic              seg_done, pass_done, sort_done;
    logic              load_room;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    // Segment bounds arithmetic
    assign lo_w      = {1'b0, lo_reg} + {1'b0, width_reg};
    assign lo_2w     = lo_w + {1'b0, width_reg};
    assign width_dbl = {width_reg, 1'b0};
    assign lo_step   = lo_2w;
    assign seg_done  = ({1'b0, k_reg} + (CW+1)'(1)) == {1'b0, hi_reg};
    assign pass_done = lo_step >= {1'b0, count_reg};
    assign sort_done = width_dbl >= {1'b0, count_reg};
    assign load_room = count_reg < CW'(DEPTH);

    // Shared compare unit: ties take the right-hand run
    assign left_val  = src_reg ? b0_reg : a0_reg;
    assign right_val = src_reg ? b1_reg : a1_reg;
    assign take_left = (i_reg < mid_reg) &&
                       ((j_reg >= hi_reg) || ($signed(left_val) < $signed(right_val)));

    // Store addressing
    assign rd_addr0 = (state_reg == ST_RD) ? i_reg[AW-1:0] : k_reg[AW-1:0];
    assign rd_addr1 = j_reg[AW-1:0];
    assign wr_addr  = (state_reg == ST_LOAD) ? count_reg[AW-1:0] : k_reg[AW-1:0];
    assign wr_data  = (state_reg == ST_LOAD) ? s_axis_tdata
                                             : (take_left ? left_val : right_val);
    assign wr_a     = ((state_reg == ST_LOAD) && in_acc && load_room) ||
                      ((state_reg == ST_MRG) && src_reg);
    assign wr_b     = (state_reg == ST_MRG) && !src_reg;

    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            mem_a[wr_addr] <= wr_data;
        end
        a0_reg <= mem_a[rd_addr0];
        a1_reg <= mem_a[rd_addr1];
    end

    always_ff @(posedge clk)
    begin
        if (wr_b)
        begin
            mem_b[wr_addr] <= wr_data;
        end
        b0_reg <= mem_b[rd_addr0];
        b1_reg <= mem_b[rd_addr1];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_acc && s_axis_tlast)
                begin
                    state_next = ST_SEG;
                end
            end
            ST_SEG:
            begin
                state_next = ST_RD;
            end
            ST_RD:
            begin
                state_next = ST_MRG;
            end
            ST_MRG:
            begin
                if (!seg_done)
                begin
                    state_next = ST_RD;
                end
                else if (pass_done && sort_done)
                begin
                    state_next = ST_OUT_RD;
                end
                else
                begin
                    state_next = ST_SEG;
                end
            end
            ST_OUT_RD:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_acc)
                begin
                    state_next = m_axis_tlast ? ST_LOAD : ST_OUT_RD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Counters and run bounds
    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        width_next = width_reg;
        lo_next    = lo_reg;
        mid_next   = mid_reg;
        hi_next    = hi_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        src_next   = src_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (load_room)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    width_next = CW'(1);
                    lo_next    = '0;
                    src_next   = 1'b0;
                    k_next     = '0;
                end
            end
            ST_SEG:
            begin
                // clip both run bounds to the item count; a lone run is copied
                mid_next = (lo_w > {1'b0, count_reg}) ? count_reg : lo_w[CW-1:0];
                hi_next  = (lo_2w > {1'b0, count_reg}) ? count_reg : lo_2w[CW-1:0];
                i_next   = lo_reg;
                j_next   = (lo_w > {1'b0, count_reg}) ? count_reg : lo_w[CW-1:0];
                k_next   = lo_reg;
            end
            ST_RD:
            begin
            end
            ST_MRG:
            begin
                if (take_left)
                begin
                    i_next = i_reg + CW'(1);
                end
                else
                begin
                    j_next = j_reg + CW'(1);
                end
                k_next = k_reg + CW'(1);
                if (seg_done)
                begin
                    if (pass_done)
                    begin
                        lo_next    = '0;
                        width_next = width_dbl[CW-1:0];
                        src_next   = !src_reg;
                        if (sort_done)
                        begin
                            k_next = '0;
                        end
                    end
                    else
                    begin
                        lo_next = lo_step[CW-1:0];
                    end
                end
            end
            ST_OUT_RD:
            begin
            end
            ST_OUT:
            begin
                if (out_acc)
                begin
                    k_next = k_reg + CW'(1);
                    if (m_axis_tlast)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        s_axis_tready = (state_reg == ST_LOAD);
        m_axis_tvalid = (state_reg == ST_OUT);
        m_axis_tdata  = src_reg ? b0_reg : a0_reg;
        m_axis_tlast  = ({1'b0, k_reg} + (CW+1)'(1)) == {1'b0, count_reg};
        m_axis_tuser  = ovf_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            width_reg <= CW'(1);
            lo_reg    <= '0;
            mid_reg   <= '0;
            hi_reg    <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            src_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            width_reg <= width_next;
            lo_reg    <= lo_next;
            mid_reg   <= mid_next;
            hi_reg    <= hi_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            src_reg   <= src_next;
        end
    end

endmodule
